// ----- rtl/lpfd_pkg.sv -----
// ----------------------------------------------------------------------------
// Length-prefixed frame deframer package
// Shared types: parse phase encoding and the result record.
// ----------------------------------------------------------------------------
package lpfd_pkg;

  localparam int unsigned LenW  = 16;
  localparam int unsigned IdW   = 32;
  localparam int unsigned ByteW = 8;

  typedef enum logic [2:0] {
    PhLenHi   = 3'd0,
    PhLenLo   = 3'd1,
    PhId      = 3'd2,
    PhPayload = 3'd3,
    PhSkip    = 3'd4
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic [IdW-1:0]   channel_id;
    logic [LenW-1:0]  payload_size;
    logic             frame_last;
    logic             empty_frame;
    logic             malformed;
  } result_t;

endpackage

// ----- rtl/lpfd_parser.sv -----
// ----------------------------------------------------------------------------
// Deframer parse stage
// Holds the parse state and turns each accepted byte into at most one result.
// ----------------------------------------------------------------------------
module lpfd_parser import lpfd_pkg::*; #(
  parameter int unsigned ID_BYTES = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] data_byte_i,
  output logic             res_valid_o,
  output result_t          res_o
);

  localparam logic [LenW-1:0] IdLen = LenW'(ID_BYTES);

  phase_e           phase_q, phase_d;
  logic [LenW-1:0]  frame_length_q, frame_length_d;
  logic [LenW-1:0]  remaining_q, remaining_d;
  logic [IdW-1:0]   id_q, id_d;

  logic [LenW-1:0]  idx;
  logic [LenW-1:0]  remaining_dec;
  logic [LenW-1:0]  len_lo;
  logic [IdW-1:0]   id_merged;

  assign idx           = frame_length_q - remaining_q;
  assign remaining_dec = remaining_q - LenW'(1);
  assign len_lo        = {frame_length_q[LenW-1:ByteW], data_byte_i};

  // Little-endian assembly: only the first four id bytes land in the id.
  always_comb begin
    id_merged = id_q;
    if (idx < LenW'(4)) begin
      case (idx[1:0])
        2'd0:    id_merged = id_q | {24'd0, data_byte_i};
        2'd1:    id_merged = id_q | {16'd0, data_byte_i, 8'd0};
        2'd2:    id_merged = id_q | {8'd0, data_byte_i, 16'd0};
        default: id_merged = id_q | {data_byte_i, 24'd0};
      endcase
    end
  end

  always_comb begin
    phase_d        = phase_q;
    frame_length_d = frame_length_q;
    remaining_d    = remaining_q;
    id_d           = id_q;
    res_valid_o    = 1'b0;
    res_o          = '0;
    unique case (phase_q)
      PhLenLo: begin
        frame_length_d = len_lo;
        remaining_d    = len_lo;
        id_d           = '0;
        if (len_lo < IdLen) begin
          phase_d           = (len_lo == '0) ? PhLenHi : PhSkip;
          res_valid_o       = 1'b1;
          res_o.frame_last  = 1'b1;
          res_o.malformed   = 1'b1;
        end else begin
          phase_d = PhId;
        end
      end
      PhId: begin
        id_d        = id_merged;
        remaining_d = remaining_dec;
        if ((idx + LenW'(1)) >= IdLen) begin
          if (remaining_dec == '0) begin
            phase_d           = PhLenHi;
            res_valid_o       = 1'b1;
            res_o.channel_id  = id_merged;
            res_o.frame_last  = 1'b1;
            res_o.empty_frame = 1'b1;
          end else begin
            phase_d = PhPayload;
          end
        end
      end
      PhPayload: begin
        remaining_d        = remaining_dec;
        res_valid_o        = 1'b1;
        res_o.payload_byte = data_byte_i;
        res_o.channel_id   = id_q;
        res_o.payload_size = frame_length_q - IdLen;
        res_o.frame_last   = (remaining_dec == '0);
        if (remaining_dec == '0) begin
          phase_d = PhLenHi;
        end
      end
      PhSkip: begin
        remaining_d = remaining_dec;
        if (remaining_dec == '0) begin
          phase_d = PhLenHi;
        end
      end
      default: begin
        frame_length_d = {data_byte_i, 8'd0};
        phase_d        = PhLenLo;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhLenHi;
      frame_length_q <= '0;
      remaining_q    <= '0;
      id_q           <= '0;
    end else if (accept_i) begin
      phase_q        <= phase_d;
      frame_length_q <= frame_length_d;
      remaining_q    <= remaining_d;
      id_q           <= id_d;
    end
  end

endmodule

// ----- rtl/lpfd_out_buf.sv -----
// ----------------------------------------------------------------------------
// Deframer result buffer
// Two-entry result register with skid slot, so input and output decouple.
// ----------------------------------------------------------------------------
module lpfd_out_buf import lpfd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    space_o,
  output logic    pop_valid_o,
  input  logic    pop_ready_i,
  output result_t pop_data_o
);

  result_t    slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       pop;

  assign space_o     = (count_q != 2'd2);
  assign pop_valid_o = (count_q != 2'd0);
  assign pop_data_o  = slot_q[rd_ptr_q];
  assign pop         = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop);
    end
  end

endmodule

// ----- rtl/length_prefixed_frame_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// Length-prefixed frame deframer
// A result is registered in the result buffer when its byte is accepted.
// Throughput: one byte per cycle while the result buffer has a free slot.
// The two-entry result buffer keeps in_ready_o high while one result waits.
// Reset (rst_ni low, asynchronous) returns parsing to the length high byte
// and empties the result buffer.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer_unit import lpfd_pkg::*; #(
  parameter int unsigned ID_BYTES = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] data_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] payload_byte_o,
  output logic [IdW-1:0]   channel_id_o,
  output logic [LenW-1:0]  payload_size_o,
  output logic             frame_last_o,
  output logic             empty_frame_o,
  output logic             malformed_o
);

  // A transaction on the input side is taken whenever the result buffer has
  // a free slot. Bytes that produce no result (header and skipped bytes)
  // still need that slot free, which keeps the rule simple and costs nothing
  // in steady state: the buffer drains one result per cycle on out_ready_i.
  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    space;

  assign in_ready_o = space;
  assign accept     = in_valid_i && space;

  // The parser updates phase, length, id and countdown on every accepted
  // byte and reports the result that byte causes, if any.
  lpfd_parser #(
    .ID_BYTES(ID_BYTES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .data_byte_i(data_byte_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // Results are registered here; the second slot absorbs one result while
  // the downstream side stalls, so the input keeps flowing.
  lpfd_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept && res_valid),
    .push_data_i(res),
    .space_o    (space),
    .pop_valid_o(out_valid_o),
    .pop_ready_i(out_ready_i),
    .pop_data_o (out_res)
  );

  assign payload_byte_o = out_res.payload_byte;
  assign channel_id_o   = out_res.channel_id;
  assign payload_size_o = out_res.payload_size;
  assign frame_last_o   = out_res.frame_last;
  assign empty_frame_o  = out_res.empty_frame;
  assign malformed_o    = out_res.malformed;

  // A malformed frame carries nothing but its flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && malformed_o) |->
      (frame_last_o && (channel_id_o == '0) && (payload_size_o == '0) &&
       (payload_byte_o == '0) && !empty_frame_o))
    else $error("malformed result carries payload data");

  // An empty frame is always a single, final result with no payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && empty_frame_o) |->
      (frame_last_o && (payload_size_o == '0) && (payload_byte_o == '0)))
    else $error("empty frame result is inconsistent");

  // With nothing buffered the block must be able to take a byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty result buffer");

  // A buffered result that is taken while the input is idle frees a slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !(in_valid_i && in_ready_o)) |=> in_ready_o)
    else $error("result buffer did not free a slot after a pop");

endmodule

// ----- verif/tb_length_prefixed_frame_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// Testbench for the length-prefixed frame deframer
// Feeds a byte stream of framed, empty and malformed frames through the
// valid/ready input and checks every result transaction against an
// in-bench model of the frame parser. Both sides idle at random, and the
// receiver holds off once for long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_length_prefixed_frame_deframer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lpfd_pkg::*;

  localparam int unsigned IdBytes    = 4;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned ByteTarget = 700;
  localparam int unsigned HoldCycles = 300;

  // Directed opening: a zero length (malformed, nothing skipped), lengths of
  // three and one (malformed, the covered bytes skipped), a frame with an
  // all-ones id and no payload, and a one-byte payload of all ones.
  localparam logic [ByteW-1:0] DirectedStream [23] = '{
    8'h00, 8'h00,
    8'h00, 8'h03, 8'hFF, 8'h00, 8'hAA,
    8'h00, 8'h01, 8'h5A,
    8'h00, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'h00, 8'h05, 8'h67, 8'h45, 8'h23, 8'h01, 8'hFF
  };

  // The scoreboard tracks the parser state itself. Every accepted byte is
  // run through the same phase machine as the block, and any result it
  // produces joins the queue of results still owed by the block.
  class frame_scoreboard;
    phase_e          phase;
    logic [LenW-1:0] frame_len;
    logic [LenW-1:0] remaining;
    logic [IdW-1:0]  id_acc;
    result_t         owed_results[$];
    int unsigned     errors;

    function new();
      phase     = PhLenHi;
      frame_len = '0;
      remaining = '0;
      id_acc    = '0;
      errors    = 0;
    endfunction

    function void note_byte(logic [ByteW-1:0] b);
      result_t         r;
      logic [LenW-1:0] offset;
      int unsigned     idx;
      r = '0;
      case (phase)
        PhLenLo: begin
          frame_len = {frame_len[LenW-1:ByteW], b};
          remaining = frame_len;
          id_acc    = '0;
          if (frame_len < LenW'(IdBytes)) begin
            phase = (frame_len == '0) ? PhLenHi : PhSkip;
            r.frame_last = 1'b1;
            r.malformed  = 1'b1;
            owed_results.push_back(r);
          end else begin
            phase = PhId;
          end
        end
        PhId: begin
          offset = frame_len - remaining;
          idx    = 32'(offset);
          if (idx < 4) id_acc = id_acc | (IdW'(b) << (8 * idx));
          remaining = remaining - LenW'(1);
          if (idx + 1 >= IdBytes) begin
            if (remaining == '0) begin
              phase = PhLenHi;
              r.channel_id  = id_acc;
              r.frame_last  = 1'b1;
              r.empty_frame = 1'b1;
              owed_results.push_back(r);
            end else begin
              phase = PhPayload;
            end
          end
        end
        PhPayload: begin
          remaining      = remaining - LenW'(1);
          r.payload_byte = b;
          r.channel_id   = id_acc;
          r.payload_size = frame_len - LenW'(IdBytes);
          r.frame_last   = (remaining == '0);
          if (remaining == '0) phase = PhLenHi;
          owed_results.push_back(r);
        end
        PhSkip: begin
          remaining = remaining - LenW'(1);
          if (remaining == '0) phase = PhLenHi;
        end
        default: begin
          frame_len = {b, 8'h00};
          phase     = PhLenLo;
        end
      endcase
    endfunction

    function void compare_field(string name, logic [IdW-1:0] want, logic [IdW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual byte 0x%0h id 0x%0h size %0d",
                 $time, got.payload_byte, got.channel_id, got.payload_size);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      compare_field("payload_byte", IdW'(want.payload_byte), IdW'(got.payload_byte));
      compare_field("channel_id",   want.channel_id,         got.channel_id);
      compare_field("payload_size", IdW'(want.payload_size), IdW'(got.payload_size));
      compare_field("frame_last",   IdW'(want.frame_last),   IdW'(got.frame_last));
      compare_field("empty_frame",  IdW'(want.empty_frame),  IdW'(got.empty_frame));
      compare_field("malformed",    IdW'(want.malformed),    IdW'(got.malformed));
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [ByteW-1:0] data_byte_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [ByteW-1:0] payload_byte_o;
  logic [IdW-1:0]   channel_id_o;
  logic [LenW-1:0]  payload_size_o;
  logic             frame_last_o;
  logic             empty_frame_o;
  logic             malformed_o;

  frame_scoreboard sb;
  bit              calm;
  bit              held_off;
  int unsigned     bytes_sent;
  int unsigned     bytes_taken;
  int unsigned     quiet_cycles;

  length_prefixed_frame_deframer_unit #(
    .ID_BYTES(IdBytes)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .payload_byte_o(payload_byte_o),
    .channel_id_o  (channel_id_o),
    .payload_size_o(payload_size_o),
    .frame_last_o  (frame_last_o),
    .empty_frame_o (empty_frame_o),
    .malformed_o   (malformed_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Idle gaps are mostly absent or short, with the occasional long one. While
  // calm is set, both sides run flat out so that back-to-back traffic is seen.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one byte and waits for its transaction. Valid stays high between
  // back-to-back bytes, so it only drops when a gap is actually inserted.
  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // A frame is its big-endian length followed by exactly that many bytes. For
  // a malformed length these are the bytes the block has to skip.
  task automatic send_frame(input logic [LenW-1:0] len);
    send_byte(len[LenW-1:ByteW]);
    send_byte(len[ByteW-1:0]);
    repeat (len) send_byte(ByteW'($urandom_range(0, 255)));
  endtask

  // Receiver: ready with random gaps. Once the stream is well under way it
  // holds off for a long stretch, which fills the result buffer and should
  // back-pressure the input while the sender keeps offering bytes.
  initial begin
    int unsigned gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      gap = pick_gap();
      if (!held_off && bytes_taken > 150) begin
        held_off = 1'b1;
        gap      = HoldCycles;
      end
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Both channels are sampled at the clock edge, before the block updates.
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_byte(data_byte_i);
        bytes_taken++;
      end
      if (out_valid_o && out_ready_i) begin
        got.payload_byte = payload_byte_o;
        got.channel_id   = channel_id_o;
        got.payload_size = payload_size_o;
        got.frame_last   = frame_last_o;
        got.empty_frame  = empty_frame_o;
        got.malformed    = malformed_o;
        sb.check_result(got);
      end
    end
  end

  // Watchdog: ends the run if neither channel completes a transaction for
  // far longer than the longest deliberate stall.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [LenW-1:0] len;
    int unsigned     kind;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    data_byte_i  = '0;
    calm         = 1'b0;
    held_off     = 1'b0;
    bytes_sent   = 0;
    bytes_taken  = 0;
    quiet_cycles = 0;
    sb           = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirectedStream[i]) send_byte(DirectedStream[i]);

    // Random part: mostly well-formed frames with random ids and payloads,
    // mixed with empty frames, malformed lengths and a few frames long enough
    // to set bits in the length high byte.
    while (bytes_sent < ByteTarget) begin
      calm = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 12) len = LenW'($urandom_range(0, IdBytes - 1));
      else if (kind < 24) len = LenW'(IdBytes);
      else if (kind < 28) len = LenW'($urandom_range(256, 300));
      else len = LenW'(IdBytes + $urandom_range(1, 24));
      send_frame(len);
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (sb.owed_results.size() != 0) @(posedge clk_i);
    // Keep watching so that any unexpected extra result is still seen and checked.
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/lpfd_pkg.sv
rtl/lpfd_parser.sv
rtl/lpfd_out_buf.sv
rtl/length_prefixed_frame_deframer_unit.sv
verif/tb_length_prefixed_frame_deframer_unit.sv
